// ----- src/ber_header_parser_top_assert.svh -----
// ----------------------------------------------------------------------------
// BER header parser assertion macros
// Property wrappers used by the parser top level to check itself.
// ----------------------------------------------------------------------------
`ifndef BER_HEADER_PARSER_TOP_ASSERT_SVH
`define BER_HEADER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define BHP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ber header parser: implication check failed");

// Next-cycle implication under reset.
`define BHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ber header parser: next-cycle check failed");

`endif

// ----- src/ber_hdr_pkg.sv -----
// ----------------------------------------------------------------------------
// BER header parser package
// Shared constants, codes and the result record of the header parser.
// ----------------------------------------------------------------------------
package ber_hdr_pkg;

  localparam int TAG_BITS      = 32;
  localparam int MAX_LEN_BYTES = 8;

  localparam logic [7:0] HIGH_TAG_CODE = 8'h1f;
  localparam logic [7:0] LEN_INDEF     = 8'h80;
  localparam logic [7:0] LEN_RESERVED  = 8'hff;
  localparam logic [7:0] COUNT_MAX     = 8'hff;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_TAG   = 2'd1,
    PH_LEN   = 2'd2,
    PH_LONG  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_EOD = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  tag_class;
    logic        is_constructed;
    logic [31:0] tag_number;
    logic        indefinite;
    logic [63:0] value_length;
    logic [7:0]  header_bytes;
  } result_t;

endpackage

// ----- src/ber_hdr_dec.sv -----
// ----------------------------------------------------------------------------
// BER header decoder
// Holds the per-header state and decodes one byte per transfer, flagging a
// result when a header finishes, fails or runs out of bytes.
// ----------------------------------------------------------------------------
module ber_hdr_dec
  import ber_hdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] byte_data,
  input  logic       byte_last,
  output logic       res_valid,
  output result_t    res
);

  phase_t                phase_r, phase_nxt;
  logic [1:0]            class_r, class_nxt;
  logic                  cons_r, cons_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [63:0]           len_r, len_nxt;
  logic [3:0]            left_r, left_nxt;
  logic [7:0]            count_r, count_inc;
  logic                  emit;
  logic                  univ_zero;

  assign count_inc = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 8'd1;
  assign univ_zero = (class_r == 2'd0) && (tag_r == '0);

  always_comb begin
    class_nxt = class_r;
    cons_nxt  = cons_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    res       = '0;
    res.status       = ST_OK;
    res.header_bytes = count_inc;
    unique case (phase_r)
      PH_FIRST: begin
        class_nxt = byte_data[7:6];
        cons_nxt  = byte_data[5];
        if (byte_data[4:0] == HIGH_TAG_CODE[4:0]) begin
          tag_nxt = '0;
        end else begin
          tag_nxt = TAG_BITS'(byte_data[4:0]);
        end
      end
      PH_TAG: begin
        tag_nxt = {tag_r[TAG_BITS-8:0], byte_data[6:0]};
      end
      PH_LEN: begin
        res.tag_class      = class_r;
        res.is_constructed = cons_r;
        res.tag_number     = 32'(tag_r);
        if (!byte_data[7]) begin
          emit = 1'b1;
          res.value_length = univ_zero ? 64'd0 : 64'(byte_data);
        end else if (byte_data == LEN_INDEF) begin
          emit = 1'b1;
          res.indefinite = 1'b1;
        end else if ((byte_data == LEN_RESERVED) ||
                     (byte_data[6:0] > 7'(MAX_LEN_BYTES))) begin
          emit = 1'b1;
          res  = '0;
          res.status       = ST_BAD;
          res.header_bytes = count_inc;
        end else begin
          len_nxt  = '0;
          left_nxt = byte_data[3:0];
        end
      end
      PH_LONG: begin
        len_nxt  = {len_r[55:0], byte_data};
        left_nxt = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;
        if (left_nxt == 4'd0) begin
          emit = 1'b1;
          res.tag_class      = class_r;
          res.is_constructed = cons_r;
          res.tag_number     = 32'(tag_r);
          res.value_length   = univ_zero ? 64'd0 : len_nxt;
        end
      end
      default: ;
    endcase
    if (!emit && byte_last) begin
      emit = 1'b1;
      res  = '0;
      res.status       = ST_EOD;
      res.header_bytes = count_inc;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (emit) begin
      phase_nxt = PH_FIRST;
    end else begin
      unique case (phase_r)
        PH_FIRST: phase_nxt = (byte_data[4:0] == HIGH_TAG_CODE[4:0]) ? PH_TAG : PH_LEN;
        PH_TAG:   phase_nxt = byte_data[7] ? PH_TAG : PH_LEN;
        PH_LEN:   phase_nxt = PH_LONG;
        PH_LONG:  phase_nxt = PH_LONG;
        default:  phase_nxt = PH_FIRST;
      endcase
    end
  end

  assign res_valid = byte_en && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      class_r <= '0;
      cons_r  <= 1'b0;
      tag_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      count_r <= '0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      if (emit) begin
        class_r <= '0;
        cons_r  <= 1'b0;
        tag_r   <= '0;
        len_r   <= '0;
        left_r  <= '0;
        count_r <= '0;
      end else begin
        class_r <= class_nxt;
        cons_r  <= cons_nxt;
        tag_r   <= tag_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
        count_r <= count_inc;
      end
    end
  end

endmodule

// ----- src/ber_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// BER header parser top level
// Byte-serial decoder of an ASN.1 BER tag/length header.
//
// Input channel: one header byte per transfer on in_data_byte, with
// in_is_last marking the final byte of the buffer. Output channel: one
// result per finished header, per bad encoding, or per buffer that ends
// before its header does; the next byte then starts a new header.
// Throughput: one byte per cycle while in_stall is low, set by the single
// decode stage between the parser state registers and the result register.
// Result path: the decode of the byte that ends a header is registered into
// the result register, or into the skid entry while out_stall holds it.
// Stall: a one-entry skid behind the result register absorbs a result while
// out_stall is high; bytes that finish no header keep flowing, and in_stall
// rises only once the skid entry is occupied.
// Reset: synchronous, active low; clears the parser to wait for a first
// byte and empties both result slots.
// ----------------------------------------------------------------------------
module ber_header_parser_top
  import ber_hdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_tag_class,
  output logic        out_is_constructed,
  output logic [31:0] out_tag_number,
  output logic        out_indefinite,
  output logic [63:0] out_value_length,
  output logic [7:0]  out_header_bytes
);

  logic    in_take;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, skid_r;
  logic    out_free;
  logic    load_out_res, load_out_skid, load_skid;

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;

  ber_hdr_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_take),
    .byte_data (in_data_byte),
    .byte_last (in_is_last),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out_res   = 1'b0;
    load_out_skid  = 1'b0;
    load_skid      = 1'b0;
    if (out_free) begin
      if (skid_valid_r) begin
        load_out_skid  = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (res_valid) begin
        load_out_res  = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      load_skid      = 1'b1;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_skid) begin
      out_r <= skid_r;
    end else if (load_out_res) begin
      out_r <= res;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_tag_class      = out_r.tag_class;
  assign out_is_constructed = out_r.is_constructed;
  assign out_tag_number     = out_r.tag_number;
  assign out_indefinite     = out_r.indefinite;
  assign out_value_length   = out_r.value_length;
  assign out_header_bytes   = out_r.header_bytes;

`include "ber_header_parser_top_assert.svh"

  `BHP_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r)
  `BHP_ASSERT_IMPL(a_no_result_when_full, res_valid, !skid_valid_r)
  `BHP_ASSERT_IMPL(a_status_code, out_valid_r,
                   (out_r.status == ST_OK) || (out_r.status == ST_EOD) ||
                   (out_r.status == ST_BAD))
  `BHP_ASSERT_IMPL(a_error_clears, out_valid_r && (out_r.status != ST_OK),
                   (out_r.tag_class == 2'd0) && (out_r.value_length == 64'd0))
  `BHP_ASSERT_NEXT(a_stalled_skid_moves, skid_valid_r && !out_stall,
                   out_valid_r && !skid_valid_r)

endmodule

// ----- tb/ber_header_parser_top_tb.sv -----
// ----------------------------------------------------------------------------
// BER header parser testbench
// Drives BER tag/length headers into the parser one byte per transfer and
// checks every result against a cycle-free decoder kept in the bench. A
// directed part hits the length forms, high tags and the error paths. Random
// traffic follows under several idle and stall mixes, with pauses that let
// the result queue drain completely.
// ----------------------------------------------------------------------------
module ber_header_parser_top_tb;
  import ber_hdr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [1:0]  out_tag_class;
  logic        out_is_constructed;
  logic [31:0] out_tag_number;
  logic        out_indefinite;
  logic [63:0] out_value_length;
  logic [7:0]  out_header_bytes;

  ber_header_parser_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_tag_class      (out_tag_class),
    .out_is_constructed (out_is_constructed),
    .out_tag_number     (out_tag_number),
    .out_indefinite     (out_indefinite),
    .out_value_length   (out_value_length),
    .out_header_bytes   (out_header_bytes)
  );

  // decoder state mirrored in the bench
  phase_t      dec_phase = PH_FIRST;
  logic [1:0]  dec_class = '0;
  logic        dec_cons = 1'b0;
  logic [31:0] dec_tag = '0;
  logic [63:0] dec_len = '0;
  logic [3:0]  dec_len_left = '0;
  logic [7:0]  dec_count = '0;

  result_t     hdr_expect_q[$];
  logic [7:0]  hdr_bytes_q[$];

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int n_ok = 0;
  int n_eod = 0;
  int n_bad = 0;
  int fail_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("ber_header_parser_top_tb: FAIL");
    $finish;
  end

  function automatic void dec_clear();
    dec_phase    = PH_FIRST;
    dec_class    = '0;
    dec_cons     = 1'b0;
    dec_tag      = '0;
    dec_len      = '0;
    dec_len_left = '0;
    dec_count    = '0;
  endfunction

  function automatic bit hdr_decode(input logic [7:0] c, input logic last,
                                    output result_t r);
    bit      done;
    bit      indef;
    bit      ok;
    status_t st;
    done  = 1'b0;
    indef = 1'b0;
    st    = ST_OK;
    r     = '0;
    if (dec_count < COUNT_MAX) dec_count = dec_count + 8'd1;
    case (dec_phase)
      PH_FIRST: begin
        dec_class = c[7:6];
        dec_cons  = c[5];
        if (c[4:0] == HIGH_TAG_CODE[4:0]) begin
          dec_tag   = '0;
          dec_phase = PH_TAG;
        end else begin
          dec_tag   = {27'b0, c[4:0]};
          dec_phase = PH_LEN;
        end
      end
      PH_TAG: begin
        dec_tag = {dec_tag[24:0], c[6:0]};
        if (!c[7]) dec_phase = PH_LEN;
      end
      PH_LEN: begin
        if (!c[7]) begin
          dec_len = {56'b0, c};
          done    = 1'b1;
        end else if (c == LEN_INDEF) begin
          indef = 1'b1;
          done  = 1'b1;
        end else if (c == LEN_RESERVED || c[6:0] > MAX_LEN_BYTES) begin
          st   = ST_BAD;
          done = 1'b1;
        end else begin
          dec_len      = '0;
          dec_len_left = c[3:0];
          dec_phase    = PH_LONG;
        end
      end
      default: begin
        dec_len = {dec_len[55:0], c};
        if (dec_len_left > 0) dec_len_left = dec_len_left - 4'd1;
        if (dec_len_left == 0) done = 1'b1;
      end
    endcase
    if (!done && last) begin
      st   = ST_EOD;
      done = 1'b1;
    end
    if (done) begin
      ok               = (st == ST_OK);
      r.status         = st;
      r.tag_class      = ok ? dec_class : 2'b0;
      r.is_constructed = ok ? dec_cons : 1'b0;
      r.tag_number     = ok ? dec_tag : 32'b0;
      r.indefinite     = ok && indef;
      r.value_length   = (!ok || indef || (dec_class == 2'b0 && dec_tag == 0)) ?
                         64'b0 : dec_len;
      r.header_bytes   = dec_count;
      dec_clear();
    end
    return done;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_is_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (hdr_decode(b, last, r)) hdr_expect_q.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_pending(input bit mark_last);
    int n;
    n = hdr_bytes_q.size();
    for (int i = 0; i < n; i++) send_byte(hdr_bytes_q[i], mark_last && (i == n - 1));
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (hdr_expect_q.size() == 0) begin
          $error("result transfer with no header pending");
          fail_count++;
        end else begin
          e = hdr_expect_q.pop_front();
          check_field("status", 64'(e.status), 64'(out_status));
          check_field("tag_class", 64'(e.tag_class), 64'(out_tag_class));
          check_field("is_constructed", 64'(e.is_constructed),
                      64'(out_is_constructed));
          check_field("tag_number", 64'(e.tag_number), 64'(out_tag_number));
          check_field("indefinite", 64'(e.indefinite), 64'(out_indefinite));
          check_field("value_length", e.value_length, out_value_length);
          check_field("header_bytes", 64'(e.header_bytes), 64'(out_header_bytes));
          case (e.status)
            ST_OK:   n_ok++;
            ST_EOD:  n_eod++;
            default: n_bad++;
          endcase
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  task automatic test_short_and_indefinite();
    hdr_bytes_q = '{8'h02, 8'h01};
    send_pending(1'b0);
    hdr_bytes_q = '{8'h30, 8'h80};
    send_pending(1'b0);
    hdr_bytes_q = '{8'h00, 8'h7f};
    send_pending(1'b0);
    hdr_bytes_q = '{8'h00, 8'h80};
    send_pending(1'b0);
  endtask

  task automatic test_high_tag_and_long_form();
    hdr_bytes_q = '{8'hff, 8'hff, 8'h7f, 8'h81, 8'hff};
    send_pending(1'b0);
    hdr_bytes_q = '{8'h44, 8'h88, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'hff, 8'hff, 8'hff, 8'hff};
    send_pending(1'b1);
  endtask

  task automatic test_bad_encoding();
    hdr_bytes_q = '{8'h04, 8'hff};
    send_pending(1'b0);
    hdr_bytes_q = '{8'h04, 8'h89};
    send_pending(1'b0);
    hdr_bytes_q = '{8'h04, 8'hff};
    send_pending(1'b1);
  endtask

  task automatic test_end_of_data();
    hdr_bytes_q = '{8'h04, 8'h82, 8'h01};
    send_pending(1'b1);
    hdr_bytes_q = '{8'h1f};
    send_pending(1'b1);
  endtask

  task automatic build_header(output bit mark_last);
    int         r;
    int         ntag;
    int         nlen;
    int         keep;
    logic [7:0] b;
    hdr_bytes_q.delete();
    mark_last = 1'b0;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4)) hdr_bytes_q.push_back(8'($urandom_range(255)));
      mark_last = 1'($urandom_range(1));
      return;
    end
    b = 8'($urandom_range(255));
    if ($urandom_range(99) < 25) begin
      b[4:0] = 5'h1f;
      hdr_bytes_q.push_back(b);
      ntag = ($urandom_range(99) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 6);
      for (int i = 0; i < ntag; i++) begin
        b    = 8'($urandom_range(255));
        b[7] = (i != ntag - 1);
        hdr_bytes_q.push_back(b);
      end
    end else begin
      b[4:0] = ($urandom_range(9) == 0) ? 5'd0 : 5'($urandom_range(30));
      hdr_bytes_q.push_back(b);
    end
    r = $urandom_range(99);
    if (r < 40) begin
      hdr_bytes_q.push_back(8'($urandom_range(127)));
    end else if (r < 55) begin
      hdr_bytes_q.push_back(LEN_INDEF);
    end else if (r < 60) begin
      hdr_bytes_q.push_back(LEN_RESERVED);
    end else if (r < 65) begin
      hdr_bytes_q.push_back(8'($urandom_range(8'h89, 8'hfe)));
    end else begin
      nlen = $urandom_range(1, MAX_LEN_BYTES);
      hdr_bytes_q.push_back(8'(8'h80 | nlen));
      repeat (nlen) hdr_bytes_q.push_back(8'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 15) begin
      mark_last = 1'b1;
    end else if (r < 30 && hdr_bytes_q.size() > 1) begin
      keep = $urandom_range(1, hdr_bytes_q.size() - 1);
      while (hdr_bytes_q.size() > keep) void'(hdr_bytes_q.pop_back());
      mark_last = 1'b1;
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_bytes);
    int start;
    bit mark_last;
    snd_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      build_header(mark_last);
      send_pending(mark_last);
    end
  endtask

  task automatic test_pause_for_results();
    in_valid <= 1'b0;
    while (hdr_expect_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_short_and_indefinite();
    test_high_tag_and_long_form();
    test_bad_encoding();
    test_end_of_data();
    test_random_traffic(0, 0, 480);
    test_pause_for_results();
    test_random_traffic(47, 0, 480);
    test_random_traffic(0, 47, 480);
    test_pause_for_results();
    test_random_traffic(25, 25, 480);
    in_valid <= 1'b0;
    while (hdr_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("bytes sent %0d, results checked %0d", bytes_sent, results_seen);
    $display("ok %0d, end of data %0d, bad encoding %0d", n_ok, n_eod, n_bad);
    if (fail_count == 0) begin
      $display("ber_header_parser_top_tb: PASS");
    end else begin
      $display("ber_header_parser_top_tb: FAIL");
    end
    $finish;
  end

endmodule
